// ----- design/sse_event_stream_parser_top_assert.svh -----
// Assertion macros shared by the event stream parser modules.
// Expects clk and rst in scope at the point of use.
`ifndef SSE_EVENT_STREAM_PARSER_TOP_ASSERT_SVH
`define SSE_EVENT_STREAM_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define SSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sse_pkg.sv -----
// Shared types and codes for the event stream parser.
// No dependencies.
`default_nettype none

package sse_pkg;

  localparam int SSE_OBUF_DEPTH = 4;

  localparam logic [1:0] BOM_START = 2'd0;
  localparam logic [1:0] BOM_EF    = 2'd1;
  localparam logic [1:0] BOM_EFBB  = 2'd2;
  localparam logic [1:0] BOM_DONE  = 2'd3;

  localparam logic [1:0] PH_NAME   = 2'd0;
  localparam logic [1:0] PH_VALUE  = 2'd1;
  localparam logic [1:0] PH_IGNORE = 2'd2;

  localparam logic [2:0] FLD_NONE  = 3'd0;
  localparam logic [2:0] FLD_DATA  = 3'd1;
  localparam logic [2:0] FLD_ID    = 3'd2;
  localparam logic [2:0] FLD_EVENT = 3'd3;
  localparam logic [2:0] FLD_RETRY = 3'd4;

  localparam logic [1:0] CAND_DATA  = 2'd0;
  localparam logic [1:0] CAND_ID    = 2'd1;
  localparam logic [1:0] CAND_EVENT = 2'd2;
  localparam logic [1:0] CAND_RETRY = 2'd3;

  localparam logic [3:0] KIND_DATA_BYTE  = 4'd0;
  localparam logic [3:0] KIND_TYPE_BEGIN = 4'd1;
  localparam logic [3:0] KIND_TYPE_BYTE  = 4'd2;
  localparam logic [3:0] KIND_ID_BEGIN   = 4'd3;
  localparam logic [3:0] KIND_ID_BYTE    = 4'd4;
  localparam logic [3:0] KIND_ID_END     = 4'd5;
  localparam logic [3:0] KIND_RETRY      = 4'd6;
  localparam logic [3:0] KIND_EVENT_END  = 4'd7;
  localparam logic [3:0] KIND_STREAM_END = 4'd8;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] BOM_B0   = 8'hEF;
  localparam logic [7:0] BOM_B1   = 8'hBB;
  localparam logic [7:0] BOM_B2   = 8'hBF;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  payload_byte;
    logic [63:0] retry_value;
    logic        flag;
    logic        last;
  } res_t;

  // results of one item, handed from the parser to the output queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [1:0]  bom;
    logic [1:0]  phase;
    logic [3:0]  name_match;
    logic [2:0]  name_pos;
    logic        name_seen;
    logic [2:0]  cur_field;
    logic        value_first;
    logic        cr_pending;
    logic        has_data;
    logic        event_pending;
    logic [63:0] retry_accum;
    logic        retry_ok;
    logic        retry_nonempty;
    logic        id_has_nul;
  } st_t;

  localparam st_t ST_RESET = '{bom: BOM_START, phase: PH_NAME, name_match: 4'hF,
                               cur_field: FLD_NONE, default: '0};

  function automatic res_t mk_res(logic [3:0] kind, logic [7:0] pb, logic [63:0] rv,
                                  logic flag);
    res_t r;
    r.kind         = kind;
    r.payload_byte = pb;
    r.retry_value  = rv;
    r.flag         = flag;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/sse_in_if.sv -----
// Input channel: stream bytes and end-of-stream commands.
// Standalone, no dependencies.
`default_nettype none

interface sse_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] stream_byte;

  modport source (output valid, cmd, stream_byte, input ready);
  modport sink   (input valid, cmd, stream_byte, output ready);
endinterface

`default_nettype wire

// ----- design/sse_out_if.sv -----
// Output channel: tagged parser results.
// Standalone, no dependencies.
`default_nettype none

interface sse_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [7:0]  payload_byte;
  logic [63:0] retry_value;
  logic        flag;
  logic        last;

  modport source (output valid, kind, payload_byte, retry_value, flag, last, input ready);
  modport sink   (input valid, kind, payload_byte, retry_value, flag, last, output ready);
endinterface

`default_nettype wire

// ----- design/sse_core.sv -----
// Input register, parser state and per-byte next-state/result logic.
// Depends on sse_pkg, sse_in_if and the assertion macro header.
`default_nettype none
`include "sse_event_stream_parser_top_assert.svh"

module sse_core (
  input  wire logic      clk,
  input  wire logic      rst,
  sse_in_if.sink         in_ch,
  input  wire logic      room,
  output sse_pkg::push_t push
);
  import sse_pkg::*;

  logic        in_vld;
  logic        in_cmd;
  logic [7:0]  in_byte;
  logic        go;
  st_t         st;
  st_t         s;
  res_t        rr [2];
  logic [1:0]  n;
  logic        do_content;
  logic        skip;
  logic        eol;
  logic        cont;
  logic        blank;
  logic        fb;
  logic        vb;
  logic [2:0]  fld;
  logic [67:0] rsum;

  function automatic logic [2:0] name_len(logic [1:0] c);
    logic [2:0] l;
    case (c)
      CAND_DATA:  l = 3'd4;
      CAND_ID:    l = 3'd2;
      CAND_EVENT: l = 3'd5;
      default:    l = 3'd5;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] name_char(logic [1:0] c, logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (c)
      CAND_DATA: begin
        case (pos)
          3'd0: ch = "d";
          3'd1: ch = "a";
          3'd2: ch = "t";
          3'd3: ch = "a";
          default: ch = 8'h00;
        endcase
      end
      CAND_ID: begin
        case (pos)
          3'd0: ch = "i";
          3'd1: ch = "d";
          default: ch = 8'h00;
        endcase
      end
      CAND_EVENT: begin
        case (pos)
          3'd0: ch = "e";
          3'd1: ch = "v";
          3'd2: ch = "e";
          3'd3: ch = "n";
          3'd4: ch = "t";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0: ch = "r";
          3'd1: ch = "e";
          3'd2: ch = "t";
          3'd3: ch = "r";
          3'd4: ch = "y";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic st_t name_byte(st_t s_in, logic [7:0] ch);
    st_t r;
    r = s_in;
    for (int c = 0; c < 4; c++) begin
      if (r.name_match[c] && (r.name_pos >= name_len(2'(c)) ||
                              name_char(2'(c), r.name_pos) != ch)) begin
        r.name_match[c] = 1'b0;
      end
    end
    if (r.name_pos != 3'd7) r.name_pos = r.name_pos + 3'd1;
    r.name_seen     = 1'b1;
    r.event_pending = 1'b1;
    return r;
  endfunction

  function automatic st_t line_reset(st_t s_in);
    st_t r;
    r = s_in;
    r.phase       = PH_NAME;
    r.name_match  = 4'hF;
    r.name_pos    = 3'd0;
    r.name_seen   = 1'b0;
    r.cur_field   = FLD_NONE;
    r.value_first = 1'b0;
    return r;
  endfunction

  // first complete candidate wins
  function automatic logic [2:0] resolve(logic [3:0] m, logic [2:0] pos);
    logic [2:0] f;
    f = FLD_NONE;
    for (int c = 3; c >= 0; c--) begin
      if (m[c] && pos == name_len(2'(c))) f = 3'(c + 1);
    end
    return f;
  endfunction

  assign go           = in_vld && room;
  assign in_ch.ready  = !in_vld || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld <= 1'b1;
    end else if (go) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_cmd  <= in_ch.cmd;
      in_byte <= in_ch.stream_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (go) begin
      st <= s;
    end
  end

  always_comb begin
    s          = st;
    n          = 2'd0;
    rr[0]      = '0;
    rr[1]      = '0;
    do_content = 1'b0;
    skip       = 1'b0;
    eol        = 1'b0;
    cont       = 1'b0;
    blank      = 1'b0;
    fb         = 1'b0;
    vb         = 1'b0;
    fld        = FLD_NONE;
    rsum       = '0;
    if (go && in_cmd) begin
      rr[0] = mk_res(KIND_STREAM_END, 8'h00, 64'd0,
                     st.event_pending || st.bom == BOM_EF || st.bom == BOM_EFBB);
      n = 2'd1;
      s = ST_RESET;
    end else if (go) begin
      // byte order mark; a broken mark replays its bytes as name bytes
      case (st.bom)
        BOM_START: begin
          if (in_byte == BOM_B0) begin
            s.bom = BOM_EF;
          end else begin
            s.bom      = BOM_DONE;
            do_content = 1'b1;
          end
        end
        BOM_EF: begin
          if (in_byte == BOM_B1) begin
            s.bom = BOM_EFBB;
          end else begin
            s.bom      = BOM_DONE;
            s          = name_byte(s, BOM_B0);
            do_content = 1'b1;
          end
        end
        BOM_EFBB: begin
          s.bom = BOM_DONE;
          if (in_byte != BOM_B2) begin
            s          = name_byte(s, BOM_B0);
            s          = name_byte(s, BOM_B1);
            do_content = 1'b1;
          end
        end
        default: do_content = 1'b1;
      endcase

      if (do_content && s.cr_pending) begin
        s.cr_pending = 1'b0;
        skip         = (in_byte == CH_LF);
      end
      eol   = do_content && !skip && (in_byte inside {CH_CR, CH_LF});
      cont  = do_content && !skip && !eol;
      blank = eol && s.phase == PH_NAME && !s.name_seen;
      fb    = s.phase == PH_NAME && s.name_seen &&
              (eol || (cont && in_byte == CH_COLON));
      vb    = cont && s.phase == PH_VALUE;

      if (eol && in_byte == CH_CR) s.cr_pending = 1'b1;

      if (blank) begin
        rr[n[0]] = mk_res(KIND_EVENT_END, 8'h00, 64'd0, s.has_data);
        n = n + 2'd1;
        s.has_data      = 1'b0;
        s.event_pending = 1'b0;
        s = line_reset(s);
      end

      if (cont) begin
        s.event_pending = 1'b1;
        if (s.phase == PH_NAME && in_byte == CH_COLON && !s.name_seen) begin
          s.phase = PH_IGNORE;
        end else if (s.phase == PH_NAME && in_byte != CH_COLON) begin
          s = name_byte(s, in_byte);
        end
      end

      if (fb) begin
        fld           = resolve(s.name_match, s.name_pos);
        s.cur_field   = fld;
        s.phase       = PH_VALUE;
        s.value_first = 1'b1;
        case (fld)
          FLD_DATA: begin
            if (s.has_data) begin
              rr[n[0]] = mk_res(KIND_DATA_BYTE, CH_LF, 64'd0, 1'b0);
              n = n + 2'd1;
            end
            s.has_data = 1'b1;
          end
          FLD_ID: begin
            rr[n[0]] = mk_res(KIND_ID_BEGIN, 8'h00, 64'd0, 1'b0);
            n = n + 2'd1;
            s.id_has_nul = 1'b0;
          end
          FLD_EVENT: begin
            rr[n[0]] = mk_res(KIND_TYPE_BEGIN, 8'h00, 64'd0, 1'b0);
            n = n + 2'd1;
          end
          FLD_RETRY: begin
            s.retry_accum    = 64'd0;
            s.retry_ok       = 1'b1;
            s.retry_nonempty = 1'b0;
          end
          default: s.phase = PH_IGNORE;
        endcase
      end

      if (eol && !blank) begin
        if (s.phase == PH_VALUE && s.cur_field == FLD_ID) begin
          rr[n[0]] = mk_res(KIND_ID_END, 8'h00, 64'd0, !s.id_has_nul);
          n = n + 2'd1;
        end else if (s.phase == PH_VALUE && s.cur_field == FLD_RETRY &&
                     s.retry_ok && s.retry_nonempty) begin
          rr[n[0]] = mk_res(KIND_RETRY, 8'h00, s.retry_accum, 1'b0);
          n = n + 2'd1;
        end
        s = line_reset(s);
      end

      if (vb) begin
        if (s.value_first && in_byte == CH_SPACE) begin
          s.value_first = 1'b0;
        end else begin
          s.value_first = 1'b0;
          case (s.cur_field)
            FLD_DATA: begin
              rr[n[0]] = mk_res(KIND_DATA_BYTE, in_byte, 64'd0, 1'b0);
              n = n + 2'd1;
            end
            FLD_ID: begin
              if (in_byte == CH_NUL) s.id_has_nul = 1'b1;
              rr[n[0]] = mk_res(KIND_ID_BYTE, in_byte, 64'd0, 1'b0);
              n = n + 2'd1;
            end
            FLD_EVENT: begin
              rr[n[0]] = mk_res(KIND_TYPE_BYTE, in_byte, 64'd0, 1'b0);
              n = n + 2'd1;
            end
            FLD_RETRY: begin
              s.retry_nonempty = 1'b1;
              if (s.retry_ok && (in_byte inside {[CH_ZERO:CH_NINE]})) begin
                // acc*10 + digit, overflow shows in the top nibble
                rsum = ({4'b0, s.retry_accum} << 3) + ({4'b0, s.retry_accum} << 1) +
                       68'(in_byte - CH_ZERO);
                if (rsum[67:64] != 4'd0) begin
                  s.retry_ok = 1'b0;
                end else begin
                  s.retry_accum = rsum[63:0];
                end
              end else begin
                s.retry_ok = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
    end

    if (n == 2'd2) begin
      rr[1].last = 1'b1;
    end else if (n == 2'd1) begin
      rr[0].last = 1'b1;
    end
  end

  assign push.cnt = n;
  assign push.r0  = rr[0];
  assign push.r1  = rr[1];

  `SSE_ASSERT_NEXT(a_eos_resets, go && in_cmd, st == ST_RESET, "stream end did not reset state")
  `SSE_ASSERT_NOW(a_last_pair, push.cnt == 2'd2, push.r1.last && !push.r0.last,
                  "last marker misplaced on result pair")
  `SSE_ASSERT_NOW(a_push_needs_go, push.cnt != 2'd0, go && in_vld,
                  "results produced without a registered item")

endmodule

`default_nettype wire

// ----- design/sse_obuf.sv -----
// Output result queue: takes up to two results a cycle, drains one.
// Depends on sse_pkg, sse_out_if and the assertion macro header.
`default_nettype none
`include "sse_event_stream_parser_top_assert.svh"

module sse_obuf #(
  parameter int DEPTH = sse_pkg::SSE_OBUF_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sse_pkg::push_t push,
  output logic                room,
  sse_out_if.source           out_ch
);
  import sse_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);
  localparam logic [CW-1:0] CNT_MAX  = CW'(DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

  res_t          q [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] wptr1;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          pop;
  res_t          head;

  function automatic logic [AW-1:0] inc(logic [AW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + AW'(1);
  endfunction

  assign wptr1      = inc(wptr);
  assign pop        = out_ch.valid && out_ch.ready;
  assign count_next = count + CW'(push.cnt) - CW'(pop);
  assign room       = count <= ROOM_MAX;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q[wptr] <= push.r0;
    if (push.cnt == 2'd2) q[wptr1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push.cnt == 2'd2) begin
        wptr <= inc(wptr1);
      end else if (push.cnt == 2'd1) begin
        wptr <= wptr1;
      end
      if (pop) rptr <= inc(rptr);
      count <= count_next;
    end
  end

  assign head                = q[rptr];
  assign out_ch.valid        = count != '0;
  assign out_ch.kind         = head.kind;
  assign out_ch.payload_byte = head.payload_byte;
  assign out_ch.retry_value  = head.retry_value;
  assign out_ch.flag         = head.flag;
  assign out_ch.last         = head.last;

  `SSE_ASSERT_NOW(a_push_room, push.cnt != 2'd0, room, "results pushed into a full queue")
  `SSE_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_MAX, "queue count out of range")
  `SSE_ASSERT_NEXT(a_drain, push.cnt == 2'd0 && pop, count == $past(count) - CW'(1),
                   "queue count not decremented on drain")

endmodule

`default_nettype wire

// ----- design/sse_event_stream_parser_top.sv -----
// Top level of the event stream parser: parser stage plus result queue.
// Depends on sse_pkg, sse_in_if, sse_out_if, sse_core and sse_obuf.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-----------------------------------------
//   in_ch    | in  | valid / ready | cmd, stream_byte
//   out_ch   | out | valid / ready | kind, payload_byte, retry_value, flag, last
//
// One byte per cycle while the queue has room; results pass the input register, then
// the queue. A byte giving two results sends them one at a time over the single port.
// Synchronous reset returns the parser to stream start and empties the queue.
// in_ch.ready drops while the input register holds a byte and the result queue
// has fewer than two free slots.
`default_nettype none

module sse_event_stream_parser_top #(
  parameter int OBUF_DEPTH = sse_pkg::SSE_OBUF_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  sse_in_if.sink    in_ch,
  sse_out_if.source out_ch
);
  import sse_pkg::*;

  push_t push;
  logic  room;

  sse_core u_core (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  sse_obuf #(
    .DEPTH (OBUF_DEPTH)
  ) u_obuf (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ----- sim/sse_event_stream_parser_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sse_event_stream_parser_top: directed and random SSE streams in, tokens checked.
// Depends on sse_pkg, sse_in_if, sse_out_if and the parser top level.

module sse_event_stream_parser_top_tb;
  import sse_pkg::*;

  typedef struct packed {
    logic       cmd;
    logic [7:0] sbyte;
  } in_item_t;

  logic clk;
  logic rst;

  sse_in_if  in_ch();
  sse_out_if out_ch();

  sse_event_stream_parser_top dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  in_item_t stream_items[$];
  res_t     step_tokens[$];
  res_t     expected_tokens[$];

  int errors = 0;
  int accepted_items = 0;
  int tx_wait, tx_wait_n;
  int rx_wait, rx_wait_n;
  int hold_left, holds_done, cyc;
  logic no_idle;
  logic offer;
  in_item_t item_now;
  res_t tok;

  // parser state mirror
  logic [1:0]  p_bom, p_phase;
  logic [3:0]  p_match;
  logic [2:0]  p_pos, p_field;
  logic        p_seen, p_vfirst, p_cr, p_has_data, p_pending;
  logic [63:0] p_racc;
  logic        p_rok, p_rne, p_idnul;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("sse_event_stream_parser_top_tb: errors");
    $finish;
  end

  task automatic report(string msg);
    if (errors < 40) $display("mismatch: %s", msg);
    errors++;
  endtask

  // ---------------- token predictor ----------------

  function automatic void add_token(logic [3:0] k, logic [7:0] b, logic [63:0] rv, logic f);
    res_t t;
    t.kind         = k;
    t.payload_byte = b;
    t.retry_value  = rv;
    t.flag         = f;
    t.last         = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic int unsigned cand_len(int c);
    case (c)
      CAND_DATA: return 4;
      CAND_ID:   return 2;
      default:   return 5;
    endcase
  endfunction

  function automatic logic [7:0] cand_char(int c, int p);
    string s;
    case (c)
      CAND_DATA:  s = "data";
      CAND_ID:    s = "id";
      CAND_EVENT: s = "event";
      default:    s = "retry";
    endcase
    return (p < s.len()) ? s[p] : CH_NUL;
  endfunction

  function automatic void line_clear();
    p_phase  = PH_NAME;
    p_match  = 4'hF;
    p_pos    = '0;
    p_seen   = 1'b0;
    p_field  = FLD_NONE;
    p_vfirst = 1'b0;
  endfunction

  function automatic void stream_reset();
    p_bom      = BOM_START;
    line_clear();
    p_cr       = 1'b0;
    p_has_data = 1'b0;
    p_pending  = 1'b0;
    p_racc     = '0;
    p_rok      = 1'b0;
    p_rne      = 1'b0;
    p_idnul    = 1'b0;
  endfunction

  function automatic void name_byte(logic [7:0] b);
    for (int c = 0; c < 4; c++)
      if (p_match[c] && (p_pos >= cand_len(c) || cand_char(c, p_pos) != b))
        p_match[c] = 1'b0;
    if (p_pos < 7) p_pos++;
    p_seen    = 1'b1;
    p_pending = 1'b1;
  endfunction

  function automatic logic [2:0] resolve_field();
    for (int c = 0; c < 4; c++)
      if (p_match[c] && p_pos == cand_len(c)) begin
        case (c)
          CAND_DATA:  return FLD_DATA;
          CAND_ID:    return FLD_ID;
          CAND_EVENT: return FLD_EVENT;
          default:    return FLD_RETRY;
        endcase
      end
    return FLD_NONE;
  endfunction

  function automatic void field_begin();
    p_field  = resolve_field();
    p_phase  = PH_VALUE;
    p_vfirst = 1'b1;
    case (p_field)
      FLD_DATA: begin
        if (p_has_data) add_token(KIND_DATA_BYTE, CH_LF, '0, 1'b0);
        p_has_data = 1'b1;
      end
      FLD_ID: begin
        add_token(KIND_ID_BEGIN, '0, '0, 1'b0);
        p_idnul = 1'b0;
      end
      FLD_EVENT: add_token(KIND_TYPE_BEGIN, '0, '0, 1'b0);
      FLD_RETRY: begin
        p_racc = '0;
        p_rok  = 1'b1;
        p_rne  = 1'b0;
      end
      default: p_phase = PH_IGNORE;
    endcase
  endfunction

  function automatic void finish_line();
    if (p_phase == PH_NAME) begin
      if (!p_seen) begin
        // blank line closes the event
        add_token(KIND_EVENT_END, '0, '0, p_has_data);
        p_has_data = 1'b0;
        p_pending  = 1'b0;
        line_clear();
        return;
      end
      field_begin();
    end
    if (p_phase == PH_VALUE) begin
      if (p_field == FLD_ID)
        add_token(KIND_ID_END, '0, '0, !p_idnul);
      else if (p_field == FLD_RETRY && p_rok && p_rne)
        add_token(KIND_RETRY, '0, p_racc, 1'b0);
    end
    line_clear();
  endfunction

  function automatic void value_byte(logic [7:0] b);
    logic [63:0] d;
    if (p_vfirst) begin
      p_vfirst = 1'b0;
      if (b == CH_SPACE) return;
    end
    case (p_field)
      FLD_DATA: add_token(KIND_DATA_BYTE, b, '0, 1'b0);
      FLD_ID: begin
        if (b == CH_NUL) p_idnul = 1'b1;
        add_token(KIND_ID_BYTE, b, '0, 1'b0);
      end
      FLD_EVENT: add_token(KIND_TYPE_BYTE, b, '0, 1'b0);
      FLD_RETRY: begin
        p_rne = 1'b1;
        if (p_rok) begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            d = {56'd0, b} - {56'd0, CH_ZERO};
            if (p_racc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
              p_rok = 1'b0;
            else
              p_racc = p_racc * 64'd10 + d;
          end else begin
            p_rok = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void content_byte(logic [7:0] b);
    if (p_cr) begin
      p_cr = 1'b0;
      if (b == CH_LF) return;
    end
    if (b == CH_CR || b == CH_LF) begin
      if (b == CH_CR) p_cr = 1'b1;
      finish_line();
      return;
    end
    p_pending = 1'b1;
    if (p_phase == PH_NAME) begin
      if (b == CH_COLON) begin
        if (!p_seen) p_phase = PH_IGNORE;
        else field_begin();
      end else begin
        name_byte(b);
      end
    end else if (p_phase == PH_VALUE) begin
      value_byte(b);
    end
  endfunction

  function automatic void parse_item(logic cmd, logic [7:0] b);
    res_t t;
    step_tokens.delete();
    if (cmd) begin
      add_token(KIND_STREAM_END, '0, '0, p_pending || p_bom == BOM_EF || p_bom == BOM_EFBB);
      stream_reset();
    end else begin
      case (p_bom)
        BOM_START:
          if (b == BOM_B0) p_bom = BOM_EF;
          else begin
            p_bom = BOM_DONE;
            content_byte(b);
          end
        BOM_EF:
          if (b == BOM_B1) p_bom = BOM_EFBB;
          else begin
            // broken mark: held bytes become name bytes
            p_bom = BOM_DONE;
            name_byte(BOM_B0);
            content_byte(b);
          end
        BOM_EFBB: begin
          p_bom = BOM_DONE;
          if (b != BOM_B2) begin
            name_byte(BOM_B0);
            name_byte(BOM_B1);
            content_byte(b);
          end
        end
        default: content_byte(b);
      endcase
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens[step_tokens.size() - 1];
      t.last = 1'b1;
      step_tokens[step_tokens.size() - 1] = t;
    end
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  // ---------------- stream builders ----------------

  task automatic queue_byte(logic [7:0] b);
    in_item_t it;
    it.cmd   = 1'b0;
    it.sbyte = b;
    stream_items.push_back(it);
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic queue_eos();
    in_item_t it;
    it.cmd   = 1'b1;
    it.sbyte = 8'($urandom_range(0, 255));
    stream_items.push_back(it);
  endtask

  task automatic queue_eol();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) queue_byte(CH_LF);
    else if (r == 1) queue_byte(CH_CR);
    else begin
      queue_byte(CH_CR);
      queue_byte(CH_LF);
    end
  endtask

  function automatic logic [7:0] value_char();
    logic [7:0] b;
    if ($urandom_range(0, 9) < 8) begin
      b = 8'($urandom_range(8'h20, 8'h7E));
    end else begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_CR || b == CH_LF) b = 8'hC3;
    end
    return b;
  endfunction

  task automatic queue_value(logic with_nul);
    int n, sp;
    n  = $urandom_range(0, 6);
    sp = $urandom_range(0, 3);
    if (sp >= 2) queue_byte(CH_SPACE);
    if (sp == 3) queue_byte(CH_SPACE);
    for (int i = 0; i < n; i++)
      if (with_nul && $urandom_range(0, 3) == 0) queue_byte(CH_NUL);
      else queue_byte(value_char());
  endtask

  task automatic queue_retry_line();
    int r, n;
    queue_text("retry:");
    if ($urandom_range(0, 2) == 0) queue_byte(CH_SPACE);
    r = $urandom_range(0, 9);
    case (r)
      0: ;
      1: queue_text("18446744073709551615");
      2: queue_text("18446744073709551616");
      3: begin
        n = $urandom_range(19, 24);
        for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
      4: begin
        queue_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        queue_byte(value_char());
        queue_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
      default: begin
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
    endcase
    queue_eol();
  endtask

  task automatic queue_odd_name();
    case ($urandom_range(0, 11))
      0:  queue_text("dat");
      1:  queue_text("datas");
      2:  queue_text("i");
      3:  queue_text("ids");
      4:  queue_text("even");
      5:  queue_text("eventx");
      6:  queue_text("retr");
      7:  queue_text("retryy");
      8:  queue_text("dataretryid");
      9:  queue_text("ID");
      10: queue_text("Data");
      default: queue_byte(value_char());
    endcase
  endtask

  task automatic queue_random_line();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      queue_text("data");
      if ($urandom_range(0, 9) != 0) begin
        queue_byte(CH_COLON);
        queue_value(1'b0);
      end
      queue_eol();
    end else if (r < 40) begin
      queue_text("id:");
      queue_value(1'b1);
      queue_eol();
    end else if (r < 50) begin
      queue_text("event:");
      queue_value(1'b0);
      queue_eol();
    end else if (r < 62) begin
      queue_retry_line();
    end else if (r < 68) begin
      queue_byte(CH_COLON);
      queue_value(1'b0);
      queue_eol();
    end else if (r < 75) begin
      queue_odd_name();
      if ($urandom_range(0, 1)) begin
        queue_byte(CH_COLON);
        queue_value(1'b0);
      end
      queue_eol();
    end else if (r < 90) begin
      queue_eol();
    end else if (r < 95) begin
      // field name with no colon
      case ($urandom_range(0, 3))
        0: queue_text("data");
        1: queue_text("id");
        2: queue_text("event");
        default: queue_text("retry");
      endcase
      queue_eol();
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      tx_wait     <= 0;
      stream_reset();
    end else begin
      tx_wait_n = tx_wait;
      offer     = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        parse_item(in_ch.cmd, in_ch.stream_byte);
        accepted_items <= accepted_items + 1;
        tx_wait_n = no_idle ? 0 : $urandom_range(0, 3);
        offer     = 1'b0;
      end else if (!in_ch.valid && tx_wait_n > 0) begin
        tx_wait_n--;
      end
      if (!offer && tx_wait_n == 0 && stream_items.size() > 0) begin
        item_now = stream_items.pop_front();
        in_ch.cmd         <= item_now.cmd;
        in_ch.stream_byte <= item_now.sbyte;
        offer = 1'b1;
      end
      in_ch.valid <= offer;
      tx_wait     <= tx_wait_n;
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_wait      <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          report($sformatf("unexpected token kind %0d", out_ch.kind));
        end else begin
          tok = expected_tokens.pop_front();
          if (out_ch.kind != tok.kind)
            report($sformatf("kind %0d, want %0d", out_ch.kind, tok.kind));
          if (out_ch.payload_byte != tok.payload_byte)
            report($sformatf("kind %0d byte %0h, want %0h", tok.kind, out_ch.payload_byte,
                             tok.payload_byte));
          if (out_ch.retry_value != tok.retry_value)
            report($sformatf("kind %0d retry %0d, want %0d", tok.kind, out_ch.retry_value,
                             tok.retry_value));
          if (out_ch.flag != tok.flag)
            report($sformatf("kind %0d flag %0b, want %0b", tok.kind, out_ch.flag, tok.flag));
          if (out_ch.last != tok.last)
            report($sformatf("kind %0d last %0b, want %0b", tok.kind, out_ch.last, tok.last));
        end
        rx_wait_n = no_idle ? 0 : $urandom_range(0, 3);
      end else if (rx_wait > 0) begin
        rx_wait_n = rx_wait - 1;
      end else begin
        rx_wait_n = 0;
      end
      rx_wait      <= rx_wait_n;
      out_ch.ready <= (rx_wait_n == 0) && (hold_left == 0);
    end
  end

  // long receiver stalls and no-idle stretches
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
      cyc        <= 0;
      no_idle    <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (cyc % 512 == 511) no_idle <= ($urandom_range(0, 3) == 0);
      if (hold_left != 0)
        hold_left <= hold_left - 1;
      else if (holds_done < 2 && accepted_items >= 400 + holds_done * 700) begin
        hold_left  <= 300;
        holds_done <= holds_done + 1;
      end
    end
  end

  // ---------------- stimulus and end of run ----------------

  initial begin
    int r, nlines;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = 1'b0;
    in_ch.stream_byte = '0;
    out_ch.ready      = 1'b0;

    // directed: full mark, CRLF, separator, blank line, NUL id, drops
    queue_byte(BOM_B0);
    queue_byte(BOM_B1);
    queue_byte(BOM_B2);
    queue_text("data: ");
    queue_byte(8'hFF);
    queue_byte(CH_CR);
    queue_byte(CH_LF);
    queue_text("data");
    queue_byte(CH_LF);
    queue_byte(CH_CR);
    queue_text("id:");
    queue_byte(CH_NUL);
    queue_byte(CH_LF);
    queue_eos();
    queue_byte(BOM_B0);
    queue_byte(CH_NUL);
    queue_eos();

    while (stream_items.size() < 1725) begin
      r = $urandom_range(0, 19);
      if (r < 3) begin
        queue_byte(BOM_B0);
        queue_byte(BOM_B1);
        queue_byte(BOM_B2);
      end else if (r == 3) begin
        queue_byte(BOM_B0);
      end else if (r == 4) begin
        queue_byte(BOM_B0);
        queue_byte(BOM_B1);
      end
      nlines = $urandom_range(0, 25);
      for (int i = 0; i < nlines; i++) queue_random_line();
      if ($urandom_range(0, 1)) queue_eol();
      queue_eos();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (stream_items.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_tokens.size() != 0)
      report($sformatf("%0d tokens never arrived", expected_tokens.size()));

    if (errors == 0)
      $display("sse_event_stream_parser_top_tb: clean");
    else
      $display("sse_event_stream_parser_top_tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/sse_pkg.sv
design/sse_in_if.sv
design/sse_out_if.sv
design/sse_core.sv
design/sse_obuf.sv
design/sse_event_stream_parser_top.sv
sim/sse_event_stream_parser_top_tb.sv
